/* sv/table_driven_pwm_generator_top_assert.svh */
// ----------------------------------------------------------------------------
// Table-driven PWM generator assertion macros
// Shared concurrent assertion forms, sampled on clk and held off by rst_n.
// ----------------------------------------------------------------------------
`ifndef TABLE_DRIVEN_PWM_GENERATOR_TOP_ASSERT_SVH
`define TABLE_DRIVEN_PWM_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication
`define TDPWM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdpwm: same-cycle check failed");

// next-cycle implication
`define TDPWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdpwm: next-cycle check failed");

`endif

/* sv/tdpwm_pkg.sv */
// ----------------------------------------------------------------------------
// Table-driven PWM generator package
// Shared types, register codes and the fixed duty and reload tables.
// ----------------------------------------------------------------------------
package tdpwm_pkg;

    localparam int MODE_BITS     = 2;
    localparam int MODE_COUNT    = 4;
    localparam int BIN_BITS      = 4;
    localparam int BIN_COUNT     = 9;
    localparam int BOUND_COUNT   = 8;
    localparam int SCALE_BITS    = 10;
    localparam int PRESCALE_BITS = 4;
    localparam int TABLE_BITS    = 8;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 1;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_FREQUENCY_MODE = 1'b0
    } reg_index_t;

    typedef logic [MODE_BITS-1:0] mode_t;
    typedef logic [BIN_BITS-1:0]  bin_t;

    typedef struct packed {
        logic pwm_level;
        logic overflow_toggle;
        logic overflow_event;
        bin_t duty_bin;
    } result_t;

    // last prescaler count of each mode: divide by 16, 8, 8, 2
    localparam logic [PRESCALE_BITS-1:0] PRESCALE_LAST [MODE_COUNT] =
        '{4'd15, 4'd7, 4'd7, 4'd1};

    // inclusive upper bounds of bins 0 to 7 on the 10-bit scale
    localparam logic [SCALE_BITS-1:0] BIN_UPPER [BOUND_COUNT] =
        '{10'd113, 10'd226, 10'd339, 10'd452, 10'd565, 10'd678, 10'd791, 10'd904};

    localparam logic [TABLE_BITS-1:0] RISE_TAB [MODE_COUNT][BIN_COUNT] = '{
        '{8'd13,  8'd33,  8'd53,  8'd83,  8'd103, 8'd123, 8'd153, 8'd173, 8'd193},
        '{8'd58,  8'd78,  8'd98,  8'd118, 8'd138, 8'd158, 8'd178, 8'd198, 8'd218},
        '{8'd135, 8'd145, 8'd155, 8'd170, 8'd185, 8'd200, 8'd215, 8'd225, 8'd235},
        '{8'd76,  8'd94,  8'd115, 8'd134, 8'd160, 8'd180, 8'd200, 8'd220, 8'd255}
    };

    localparam logic [TABLE_BITS-1:0] FALL_TAB [MODE_COUNT][BIN_COUNT] = '{
        '{8'd193, 8'd173, 8'd153, 8'd123, 8'd103, 8'd83,  8'd53,  8'd33,  8'd13},
        '{8'd218, 8'd198, 8'd178, 8'd158, 8'd138, 8'd118, 8'd98,  8'd78,  8'd58},
        '{8'd235, 8'd225, 8'd215, 8'd200, 8'd185, 8'd170, 8'd155, 8'd145, 8'd135},
        '{8'd255, 8'd220, 8'd200, 8'd180, 8'd154, 8'd134, 8'd115, 8'd94,  8'd76}
    };

endpackage

/* sv/tdpwm_if.sv */
// ----------------------------------------------------------------------------
// Table-driven PWM generator channels
// Valid/ready channels for duty samples and for PWM results.
// ----------------------------------------------------------------------------
interface tdpwm_sample_if #(
    parameter int SAMPLE_BITS = 10
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] duty_sample;

    modport source (output valid, output duty_sample, input ready);
    modport sink   (input valid, input duty_sample, output ready);
endinterface

interface tdpwm_result_if ();
    logic                  valid;
    logic                  ready;
    logic                  pwm_level;
    logic                  overflow_toggle;
    logic                  overflow_event;
    logic [tdpwm_pkg::BIN_BITS-1:0] duty_bin;

    modport source (output valid, output pwm_level, output overflow_toggle,
                    output overflow_event, output duty_bin, input ready);
    modport sink   (input valid, input pwm_level, input overflow_toggle,
                    input overflow_event, input duty_bin, output ready);
endinterface

/* sv/tdpwm_cfg.sv */
// ----------------------------------------------------------------------------
// Table-driven PWM generator configuration registers
// APB-style register file holding the frequency mode.
// ----------------------------------------------------------------------------
module tdpwm_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tdpwm_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [tdpwm_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [tdpwm_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                pready,
    output tdpwm_pkg::mode_t                    mode
);

    tdpwm_pkg::reg_index_t reg_idx;
    tdpwm_pkg::mode_t      mode_reg;
    tdpwm_pkg::mode_t      mode_next;
    logic                  wr_en;

    assign reg_idx = tdpwm_pkg::reg_index_t'(paddr[tdpwm_pkg::APB_ADDR_BITS-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign mode    = mode_reg;

    always_comb
    begin
        mode_next = mode_reg;
        if (wr_en && (reg_idx == tdpwm_pkg::REG_FREQUENCY_MODE))
        begin
            mode_next = pwdata[tdpwm_pkg::MODE_BITS-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            tdpwm_pkg::REG_FREQUENCY_MODE:
            begin
                prdata = tdpwm_pkg::APB_DATA_BITS'(mode_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

/* sv/tdpwm_bin_map.sv */
// ----------------------------------------------------------------------------
// Table-driven PWM generator duty binning
// Scales a duty sample to 10 bits and maps it onto one of nine duty bins.
// ----------------------------------------------------------------------------
module tdpwm_bin_map #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic [SAMPLE_BITS-1:0] duty_sample,
    output tdpwm_pkg::bin_t        duty_bin
);

    logic [tdpwm_pkg::SCALE_BITS-1:0] scaled;

    generate
        if (SAMPLE_BITS >= tdpwm_pkg::SCALE_BITS)
        begin : g_shift_down
            assign scaled = duty_sample[SAMPLE_BITS-1 -: tdpwm_pkg::SCALE_BITS];
        end
        else
        begin : g_shift_up
            assign scaled = {duty_sample, {(tdpwm_pkg::SCALE_BITS-SAMPLE_BITS){1'b0}}};
        end
    endgenerate

    // lowest bin whose upper bound covers the sample
    always_comb
    begin
        duty_bin = tdpwm_pkg::bin_t'(tdpwm_pkg::BOUND_COUNT);
        for (int k = tdpwm_pkg::BOUND_COUNT - 1; k >= 0; k--)
        begin
            if (scaled <= tdpwm_pkg::BIN_UPPER[k])
            begin
                duty_bin = tdpwm_pkg::bin_t'(k);
            end
        end
    end

endmodule

/* sv/tdpwm_timer.sv */
// ----------------------------------------------------------------------------
// Table-driven PWM generator timer
// Prescaler, reloading up-counter and PWM/toggle line state for one tick.
// ----------------------------------------------------------------------------
`include "table_driven_pwm_generator_top_assert.svh"

module tdpwm_timer #(
    parameter int TIMER_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  tdpwm_pkg::mode_t    mode,
    input  tdpwm_pkg::bin_t     duty_bin,
    output tdpwm_pkg::result_t  result
);

    logic [tdpwm_pkg::PRESCALE_BITS-1:0] prescale_count_reg;
    logic [tdpwm_pkg::PRESCALE_BITS-1:0] prescale_count_next;
    logic [TIMER_BITS-1:0]               timer_count_reg;
    logic [TIMER_BITS-1:0]               timer_count_next;
    logic                                phase_flag_reg;
    logic                                phase_flag_next;
    logic                                pwm_line_reg;
    logic                                pwm_line_next;
    logic                                toggle_line_reg;
    logic                                toggle_line_next;
    logic                                prescale_end;
    logic                                timer_full;
    logic                                wrap;
    logic [TIMER_BITS-1:0]               rise_value;
    logic [TIMER_BITS-1:0]               fall_value;

    assign prescale_end = prescale_count_reg >= tdpwm_pkg::PRESCALE_LAST[mode];
    assign timer_full   = &timer_count_reg;
    assign wrap         = prescale_end && timer_full;
    assign rise_value   = TIMER_BITS'(tdpwm_pkg::RISE_TAB[mode][duty_bin]);
    assign fall_value   = TIMER_BITS'(tdpwm_pkg::FALL_TAB[mode][duty_bin]);

    always_comb
    begin
        prescale_count_next = prescale_count_reg + 1'b1;
        timer_count_next    = timer_count_reg;
        phase_flag_next     = phase_flag_reg;
        pwm_line_next       = pwm_line_reg;
        toggle_line_next    = toggle_line_reg;
        if (prescale_end)
        begin
            prescale_count_next = '0;
            if (timer_full)
            begin
                toggle_line_next = !toggle_line_reg;
                phase_flag_next  = !phase_flag_reg;
                // leave phase 0: drop line, load rising value; else raise, load falling
                if (!phase_flag_reg)
                begin
                    pwm_line_next    = 1'b0;
                    timer_count_next = rise_value;
                end
                else
                begin
                    pwm_line_next    = 1'b1;
                    timer_count_next = fall_value;
                end
            end
            else
            begin
                timer_count_next = timer_count_reg + 1'b1;
            end
        end
    end

    assign result.pwm_level       = pwm_line_next;
    assign result.overflow_toggle = toggle_line_next;
    assign result.overflow_event  = wrap;
    assign result.duty_bin        = duty_bin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg <= '0;
            timer_count_reg    <= '0;
            phase_flag_reg     <= 1'b0;
            pwm_line_reg       <= 1'b0;
            toggle_line_reg    <= 1'b0;
        end
        else if (step)
        begin
            prescale_count_reg <= prescale_count_next;
            timer_count_reg    <= timer_count_next;
            phase_flag_reg     <= phase_flag_next;
            pwm_line_reg       <= pwm_line_next;
            toggle_line_reg    <= toggle_line_next;
        end
    end

    `TDPWM_ASSERT_NOW(a_phase_tracks_toggle, 1'b1, phase_flag_reg == toggle_line_reg)
    `TDPWM_ASSERT_NEXT(a_hold_without_step, !step,
        $stable(timer_count_reg) && $stable(prescale_count_reg) && $stable(pwm_line_reg))
    `TDPWM_ASSERT_NEXT(a_count_only_on_prescale_end, step && !prescale_end,
        timer_count_reg == $past(timer_count_reg))
    `TDPWM_ASSERT_NEXT(a_wrap_flips_lines, step && wrap,
        (toggle_line_reg != $past(toggle_line_reg)) && (pwm_line_reg == !phase_flag_reg))

endmodule

/* sv/table_driven_pwm_generator_top.sv */
// ----------------------------------------------------------------------------
// Table-driven PWM generator
// Prescaled reloading timer that drives a PWM line from a duty-bin table.
// ----------------------------------------------------------------------------
// Each request is one instruction-clock tick carrying a duty sample; the block
// returns one result per request, one request per cycle sustained while the
// result channel is not stalled. A request passes an input register; the
// prescaler, counter, bin compare and table reload then settle combinationally
// into the result register. A stalled result register holds both stages; the
// input stage still takes a request while its own slot is free. Write the
// frequency mode (byte address 0) only while no request is in flight.
module table_driven_pwm_generator_top #(
    parameter int TIMER_BITS  = 8,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    tdpwm_sample_if.sink                        samples,
    tdpwm_result_if.source                      results,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tdpwm_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [tdpwm_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [tdpwm_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                pready
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    tdpwm_pkg::result_t     out_reg;
    logic                   out_free;
    logic                   advance;
    tdpwm_pkg::mode_t       mode;
    tdpwm_pkg::bin_t        duty_bin;
    tdpwm_pkg::result_t     result;

    tdpwm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mode    (mode)
    );

    tdpwm_bin_map #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_bin_map (
        .duty_sample (sample_reg),
        .duty_bin    (duty_bin)
    );

    tdpwm_timer #(
        .TIMER_BITS (TIMER_BITS)
    ) u_timer (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .mode     (mode),
        .duty_bin (duty_bin),
        .result   (result)
    );

    assign out_free      = !out_valid_reg || results.ready;
    assign advance       = in_valid_reg && out_free;
    assign samples.ready = !in_valid_reg || out_free;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (samples.ready)
        begin
            in_valid_next = samples.valid;
        end
        if (out_free)
        begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            sample_reg <= samples.duty_sample;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.pwm_level       = out_reg.pwm_level;
    assign results.overflow_toggle = out_reg.overflow_toggle;
    assign results.overflow_event  = out_reg.overflow_event;
    assign results.duty_bin        = out_reg.duty_bin;

endmodule
